>>> sv/jcpp_pkg.sv
// Shared types, tag codes and helpers for the constant-pool parser.
// Used by jcpp_step and java_constant_pool_parser; depends on nothing.
package jcpp_pkg;

    // Parser phase
    typedef enum logic [1:0] {
        PH_TAG,
        PH_PAYLOAD,
        PH_SKIP
    } phase_t;

    // Constant-pool tag codes
    localparam logic [7:0] TAG_UTF8        = 8'd1;
    localparam logic [7:0] TAG_INTEGER     = 8'd3;
    localparam logic [7:0] TAG_FLOAT       = 8'd4;
    localparam logic [7:0] TAG_LONG        = 8'd5;
    localparam logic [7:0] TAG_DOUBLE      = 8'd6;
    localparam logic [7:0] TAG_CLASS       = 8'd7;
    localparam logic [7:0] TAG_STRING      = 8'd8;
    localparam logic [7:0] TAG_FIELDREF    = 8'd9;
    localparam logic [7:0] TAG_METHODREF   = 8'd10;
    localparam logic [7:0] TAG_IFMETHODREF = 8'd11;
    localparam logic [7:0] TAG_NAMETYPE    = 8'd12;

    // Result status codes
    localparam logic [1:0] STATUS_WORD    = 2'd0;
    localparam logic [1:0] STATUS_BAD_TAG = 2'd1;
    localparam logic [1:0] STATUS_OVERRUN = 2'd2;

    // Payload lengths in bytes
    localparam logic [3:0] LEN_NONE = 4'd0;
    localparam logic [3:0] LEN_U2   = 4'd2;
    localparam logic [3:0] LEN_U4   = 4'd4;
    localparam logic [3:0] LEN_WIDE = 4'd8;

    // Register indexes and reset values
    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_POOL_OFFSET = 1'b1;
    localparam logic [15:0] ENTRY_COUNT_RESET = 16'd1;
    localparam logic [31:0] POOL_OFFSET_RESET = 32'd10;

    // Parser state
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  cur_tag;
        logic [2:0]  bytes_seen;
        logic [31:0] acc;
        logic [15:0] entry_pos;
        logic [31:0] byte_pos;
        logic [15:0] skip_rem;
        logic        halted;
    } state_t;

    // One result beat
    typedef struct packed {
        logic [15:0] entry_index;
        logic [7:0]  tag;
        logic [31:0] value;
        logic [1:0]  status;
        logic        pool_done;
    } result_t;

    // Payload length of a tag, LEN_NONE for an unknown tag
    function automatic logic [3:0] payload_len(input logic [7:0] t);
        logic [3:0] len;
        unique case (t)
            TAG_UTF8, TAG_CLASS, TAG_STRING:           len = LEN_U2;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF,
            TAG_METHODREF, TAG_IFMETHODREF,
            TAG_NAMETYPE:                              len = LEN_U4;
            TAG_LONG, TAG_DOUBLE:                      len = LEN_WIDE;
            default:                                   len = LEN_NONE;
        endcase
        return len;
    endfunction

endpackage

>>> sv/jcpp_step.sv
// Next-state and result logic for one pool byte of the constant-pool parser.
// Depends on jcpp_pkg.
module jcpp_step
(
    input  jcpp_pkg::state_t  state,
    input  logic [7:0]        byte_in,
    input  logic              first,
    input  logic [15:0]       entry_count,
    input  logic [31:0]       pool_offset,
    output jcpp_pkg::state_t  state_next,
    output logic              res_valid,
    output jcpp_pkg::result_t res
);

    jcpp_pkg::state_t s;
    logic [3:0]  need;
    logic [3:0]  cnt;
    logic [31:0] acc_new;
    logic [16:0] epos_next;
    logic [16:0] count_ext;

    // Restart on a first byte
    always_comb
    begin
        s = state;
        if (first)
        begin
            s.halted     = 1'b0;
            s.phase      = jcpp_pkg::PH_TAG;
            s.entry_pos  = 16'd1;
            s.byte_pos   = pool_offset;
            s.bytes_seen = 3'd0;
            s.acc        = 32'd0;
            s.skip_rem   = 16'd0;
        end
    end

    assign count_ext = {1'b0, entry_count};
    assign cnt       = {1'b0, s.bytes_seen} + 4'd1;
    assign acc_new   = {s.acc[23:0], byte_in};

    // Byte handling per phase
    always_comb
    begin
        state_next = s;
        res_valid  = 1'b0;
        res        = '0;
        need       = jcpp_pkg::LEN_NONE;
        epos_next  = {1'b0, s.entry_pos};
        if (!s.halted)
        begin
            unique case (s.phase)
                jcpp_pkg::PH_SKIP:
                begin
                    state_next.byte_pos = s.byte_pos + 32'd1;
                    state_next.skip_rem = s.skip_rem - 16'd1;
                    if (s.skip_rem == 16'd1)
                        state_next.phase = jcpp_pkg::PH_TAG;
                end
                jcpp_pkg::PH_TAG:
                begin
                    need = jcpp_pkg::payload_len(byte_in);
                    epos_next = {1'b0, s.entry_pos} + 17'd1;
                    if (s.entry_pos < entry_count)
                    begin
                        state_next.byte_pos = s.byte_pos + 32'd1;
                        res.entry_index = s.entry_pos;
                        res.tag         = byte_in;
                        if (need == jcpp_pkg::LEN_NONE)
                        begin
                            state_next.halted = 1'b1;
                            res_valid  = 1'b1;
                            res.status = jcpp_pkg::STATUS_BAD_TAG;
                        end
                        else if (need == jcpp_pkg::LEN_WIDE && epos_next >= count_ext)
                        begin
                            state_next.halted = 1'b1;
                            res_valid  = 1'b1;
                            res.status = jcpp_pkg::STATUS_OVERRUN;
                        end
                        else
                        begin
                            state_next.cur_tag    = byte_in;
                            state_next.bytes_seen = 3'd0;
                            state_next.acc        = 32'd0;
                            state_next.phase      = jcpp_pkg::PH_PAYLOAD;
                        end
                    end
                end
                jcpp_pkg::PH_PAYLOAD:
                begin
                    need = jcpp_pkg::payload_len(s.cur_tag);
                    state_next.byte_pos   = s.byte_pos + 32'd1;
                    state_next.bytes_seen = cnt[2:0];
                    state_next.acc        = acc_new;
                    res.tag    = s.cur_tag;
                    res.status = jcpp_pkg::STATUS_WORD;
                    // high word of a wide entry goes to index+1
                    if (need == jcpp_pkg::LEN_WIDE && cnt == 4'd4)
                    begin
                        res_valid       = 1'b1;
                        res.entry_index = s.entry_pos + 16'd1;
                        res.value       = acc_new;
                        state_next.acc  = 32'd0;
                    end
                    else if (cnt >= need)
                    begin
                        res_valid       = 1'b1;
                        res.entry_index = s.entry_pos;
                        if (s.cur_tag == jcpp_pkg::TAG_UTF8)
                        begin
                            // offset of the first length byte
                            epos_next = {1'b0, s.entry_pos} + 17'd1;
                            res.value = s.byte_pos - 32'd1;
                            state_next.skip_rem = acc_new[15:0];
                            state_next.phase = (acc_new[15:0] != 16'd0) ?
                                jcpp_pkg::PH_SKIP : jcpp_pkg::PH_TAG;
                        end
                        else
                        begin
                            epos_next = {1'b0, s.entry_pos} +
                                ((need == jcpp_pkg::LEN_WIDE) ? 17'd2 : 17'd1);
                            res.value = acc_new;
                            state_next.phase = jcpp_pkg::PH_TAG;
                        end
                        res.pool_done         = (epos_next >= count_ext);
                        state_next.entry_pos  = epos_next[15:0];
                        state_next.bytes_seen = 3'd0;
                        state_next.acc        = 32'd0;
                    end
                end
                default:
                begin
                    state_next.phase = jcpp_pkg::PH_TAG;
                end
            endcase
        end
    end

endmodule

>>> sv/java_constant_pool_parser.sv
// Top level of the constant-pool parser: stream ports, registers, pipeline.
// Depends on jcpp_pkg and jcpp_step.
//
// The parser takes one constant-pool byte per beat and can accept a beat in
// every clock cycle. Each byte passes an input register, the per-byte parse
// logic, and a result register, from which its result beat is offered. The
// input side stalls only while the result register holds a beat that the
// downstream side has not taken. Bytes that end no definition word (known
// tags, partial payloads, UTF8 text) produce no beat. After an unknown tag
// or a wide entry at the last index the parser halts until a byte marked
// first. Register writes are taken at any cycle and are meant for an idle
// parser.
module java_constant_pool_parser
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tuser,   // [0] first
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [15:0] entry_index, [23:16] tag, [55:24] value
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // pool_done
);

    logic [15:0] entry_count_reg;
    logic [31:0] pool_offset_reg;

    jcpp_pkg::state_t  state_reg;
    jcpp_pkg::state_t  state_next;
    jcpp_pkg::result_t res;
    jcpp_pkg::result_t out_reg;
    logic              res_valid;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       out_valid_reg;
    logic       fire;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= jcpp_pkg::ENTRY_COUNT_RESET;
            pool_offset_reg <= jcpp_pkg::POOL_OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                jcpp_pkg::REG_ENTRY_COUNT: entry_count_reg <= cfg_data[15:0];
                jcpp_pkg::REG_POOL_OFFSET: pool_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Parse a held byte when the result register is free or being drained
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    jcpp_step u_step
    (
        .state       (state_reg),
        .byte_in     (in_byte_reg),
        .first       (in_first_reg),
        .entry_count (entry_count_reg),
        .pool_offset (pool_offset_reg),
        .state_next  (state_next),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= jcpp_pkg::PH_TAG;
            state_reg.cur_tag    <= 8'd0;
            state_reg.bytes_seen <= 3'd0;
            state_reg.acc        <= 32'd0;
            state_reg.entry_pos  <= 16'd1;
            state_reg.byte_pos   <= jcpp_pkg::POOL_OFFSET_RESET;
            state_reg.skip_rem   <= 16'd0;
            state_reg.halted     <= 1'b0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= res_valid;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.value, out_reg.tag, out_reg.entry_index};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.pool_done;

endmodule
